// File: hw/rtl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types, constants and float helpers of the block dequantizer.
// ----------------------------------------------------------------------------
`default_nettype none
package bqd_pkg;

    typedef enum logic [1:0] {
        FMT_F32  = 2'd0,
        FMT_F16  = 2'd1,
        FMT_Q4_0 = 2'd2,
        FMT_Q8_0 = 2'd3
    } fmt_t;

    localparam int ROW_INDEX_BITS_DEF = 16;
    localparam logic [5:0] Q4_BLOCK_BYTES = 6'd18;
    localparam logic [5:0] Q8_BLOCK_BYTES = 6'd34;
    localparam logic [0:0] REG_FORMAT     = 1'd0;
    localparam logic [0:0] REG_ROW_LENGTH = 1'd1;
    localparam logic [15:0] ROW_LENGTH_RST = 16'd32;

    typedef struct packed {
        logic        two;    // two results pending
        logic [31:0] v0;
        logic        end0;
        logic [31:0] v1;
        logic        end1;
    } res_pair_t;

    function automatic logic [3:0] msb10(input logic [9:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (v[i]) p = 4'(i);
        end
        return p;
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  f;
        logic [3:0]  p;
        logic [31:0] r;
        e = h[14:10];
        f = h[9:0];
        p = msb10(f);
        if (e == 5'h1F) begin
            r = {h[15], 8'hFF, f, 13'd0};
        end else if (e == 5'd0) begin
            if (f == 10'd0) r = {h[15], 31'd0};
            else begin
                r = {h[15], 8'(p + 4'd0) + 8'd103, 23'(({13'd0, f} << (5'd23 - 5'(p))))};
            end
        end else begin
            r = {h[15], 8'(e) + 8'd112, f, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [4:0] msb19(input logic [18:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 19; i++) begin
            if (v[i]) p = 5'(i);
        end
        return p;
    endfunction

    // exact single of k * half(h), |k| <= 128
    function automatic logic [31:0] scaled(input logic [15:0] h, input logic [7:0] k);
        logic        sgn;
        logic [4:0]  e;
        logic [9:0]  f;
        logic [7:0]  ak;
        logic [10:0] m;
        logic [18:0] prod;
        logic [4:0]  p;
        logic [8:0]  ex;
        logic [31:0] r;
        sgn  = h[15] ^ k[7];
        e    = h[14:10];
        f    = h[9:0];
        ak   = k[7] ? (8'd0 - k) : k;
        m    = (e == 5'd0) ? {1'b0, f} : {1'b1, f};
        prod = {8'd0, m} * {11'd0, ak};
        p    = msb19(prod);
        // p + ex + 127, ex = -24 (subnormal) or e-25
        ex   = (e == 5'd0) ? (9'(p) + 9'd103) : (9'(p) + 9'(e) + 9'd102);
        if (e == 5'h1F) begin
            if (f != 10'd0) r = half_to_single(h) | 32'h0040_0000;
            else if (ak == 8'd0) r = 32'h7FC0_0000;
            else r = {sgn, 8'hFF, 23'd0};
        end else if (m == 11'd0 || ak == 8'd0) begin
            r = {sgn, 31'd0};
        end else begin
            r = {sgn, ex[7:0], 23'({4'd0, prod} << (5'd23 - p))};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bqd_core.sv
// ----------------------------------------------------------------------------
// bqd_core
// Per-byte decode: position tracking, gathering and scaling into result pair.
// ----------------------------------------------------------------------------
`default_nettype none
module bqd_core #(
    parameter int ROW_INDEX_BITS = bqd_pkg::ROW_INDEX_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              start_req,
    input  wire logic [1:0]        format,
    input  wire logic [15:0]       row_length,
    output bqd_pkg::res_pair_t     res,
    output logic [1:0]             res_count
);
    localparam logic [ROW_INDEX_BITS-1:0] CAP = '1;

    logic [5:0]                byte_position_reg, byte_position_next;
    logic [15:0]               scale_half_reg, scale_half_next;
    logic [23:0]               partial_word_reg, partial_word_next;
    logic [ROW_INDEX_BITS-1:0] element_in_row_reg, element_in_row_next;

    logic [5:0]                size, pos, pos_inc;
    logic [ROW_INDEX_BITS-1:0] len, eir, eir1, eir2;
    logic [32:0]               len_w;
    logic                      blk;

    always_comb begin
        len_w = {17'd0, row_length};
        if (row_length == 16'd0) len_w = 33'd1;
        if (len_w > 33'(CAP)) len = CAP;
        else len = len_w[ROW_INDEX_BITS-1:0];
    end

    always_comb begin
        case (format)
            bqd_pkg::FMT_F32:  size = 6'd4;
            bqd_pkg::FMT_F16:  size = 6'd2;
            bqd_pkg::FMT_Q4_0: size = bqd_pkg::Q4_BLOCK_BYTES;
            default:           size = bqd_pkg::Q8_BLOCK_BYTES;
        endcase
        blk  = format[1];
        eir  = start_req ? '0 : element_in_row_reg;
        pos  = start_req ? 6'd0 : byte_position_reg;
        if (pos >= size) pos = 6'd0;
        eir1 = eir + 1'b1;
        eir2 = eir + 2'd2;

        byte_position_next  = byte_position_reg;
        scale_half_next     = scale_half_reg;
        partial_word_next   = partial_word_reg;
        element_in_row_next = eir;
        res       = '0;
        res_count = 2'd0;
        res.end0  = {1'b0, eir1} >= {1'b0, len} || eir1 == '0;
        res.end1  = {1'b0, eir2} >= {1'b0, len} || eir2 < eir1 || eir2 == '0;
        if (eir1 == '0) res.end0 = ({1'b1, eir1} >= {1'b0, len});
        if (eir2 == '0 || eir2 == '1 && eir1 == '0)
            res.end1 = 1'b1;

        case (format)
            bqd_pkg::FMT_F32: begin
                if (pos == 6'd0) partial_word_next = {16'd0, data_byte};
                else if (pos == 6'd1)
                    partial_word_next = partial_word_reg | {8'd0, data_byte, 8'd0};
                else if (pos == 6'd2)
                    partial_word_next = partial_word_reg | {data_byte, 16'd0};
                else begin
                    res.v0 = {data_byte, partial_word_reg};
                    res_count = 2'd1;
                    element_in_row_next = ({1'b0, eir1} >= {1'b0, len}) ? '0 : eir1;
                end
            end
            bqd_pkg::FMT_F16: begin
                if (pos == 6'd0) partial_word_next = {16'd0, data_byte};
                else begin
                    res.v0 = bqd_pkg::half_to_single({data_byte, partial_word_reg[7:0]});
                    res_count = 2'd1;
                    element_in_row_next = ({1'b0, eir1} >= {1'b0, len}) ? '0 : eir1;
                end
            end
            default: begin
                if (pos == 6'd0) scale_half_next = {8'd0, data_byte};
                else if (pos == 6'd1) scale_half_next = {data_byte, scale_half_reg[7:0]};
                else if (format == bqd_pkg::FMT_Q8_0) begin
                    if (eir < len) begin
                        res.v0 = bqd_pkg::scaled(scale_half_reg, data_byte);
                        res_count = 2'd1;
                        element_in_row_next = eir1;
                    end
                end else begin
                    res.v0 = bqd_pkg::scaled(scale_half_reg,
                        {{4{data_byte[3]}}, data_byte[3:0]});
                    res.v1 = bqd_pkg::scaled(scale_half_reg,
                        {{4{data_byte[7]}}, data_byte[7:4]});
                    if (eir < len) begin
                        element_in_row_next = eir1;
                        if (eir1 < len && eir1 != '0) begin
                            res_count = 2'd2;
                            element_in_row_next = eir2;
                        end else begin
                            res_count = 2'd1;
                        end
                    end
                end
            end
        endcase
        res.two = (res_count == 2'd2);

        pos_inc = pos + 6'd1;
        if (pos_inc >= size) begin
            pos_inc = 6'd0;
            if (blk && element_in_row_next >= len) element_in_row_next = '0;
        end
        byte_position_next = pos_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= '0;
            scale_half_reg     <= '0;
            partial_word_reg   <= '0;
            element_in_row_reg <= '0;
        end else if (step) begin
            byte_position_reg  <= byte_position_next;
            scale_half_reg     <= scale_half_next;
            partial_word_reg   <= partial_word_next;
            element_in_row_reg <= element_in_row_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/bqd_out.sv
// ----------------------------------------------------------------------------
// bqd_out
// Result register holding up to two results; drains one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module bqd_out (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire bqd_pkg::res_pair_t res,
    input  wire logic [1:0]         res_count,
    output logic                    ready_in,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser
);
    logic [1:0]         cnt_reg, cnt_next;
    bqd_pkg::res_pair_t buf_reg;
    logic               fire;

    assign fire     = m_tvalid && m_tready;
    assign ready_in = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = (cnt_reg == 2'd2) ? buf_reg.v0 : (buf_reg.two ? buf_reg.v1 : buf_reg.v0);
    assign m_tuser  = (cnt_reg == 2'd2) ? buf_reg.end0 : (buf_reg.two ? buf_reg.end1 : buf_reg.end0);
    assign m_tlast  = cnt_reg == 2'd1;

    always_comb begin
        cnt_next = cnt_reg - {1'b0, fire};
        if (load) cnt_next = res_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= 2'd0;
        else cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (load) buf_reg <= res;
    end
endmodule
`default_nettype wire

// File: hw/rtl/block_quant_dequantizer_top.sv
// ----------------------------------------------------------------------------
// block_quant_dequantizer_top
// Byte-stream tensor dequantizer to single precision.
// ----------------------------------------------------------------------------
// Input: one stored byte per transfer on s_tdata, s_tuser marks the first byte
// of a tensor. Output: m_tdata is the single precision element, m_tuser marks
// the last element of a row, m_tlast the last result caused by its byte.
// A byte is decoded in the cycle it is taken; its results are visible on the
// next cycle. One byte per cycle is sustained for f32, f16 and q8_0 (at most
// one result per byte) while the receiver is ready; a q4_0 quant byte yields
// two results, and no new byte is taken until the first of them has drained,
// bound by the single result port.
// Reset clears position counters, scale and format (f32, row length 32).
// When the receiver stalls, the pending results hold and s_tready drops once
// the result register cannot take a new byte's output.
// Configuration goes through the APB port: format at 0x0, row_length at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none
module block_quant_dequantizer_top #(
    parameter int ROW_INDEX_BITS = bqd_pkg::ROW_INDEX_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value_bits
    output logic             m_tlast,   // last_in_run
    output logic             m_tuser,   // row_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [1:0]         format_reg;
    logic [15:0]        row_length_reg;
    logic               step;
    bqd_pkg::res_pair_t res;
    logic [1:0]         res_count;

    assign pready = 1'b1;
    assign step   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg     <= bqd_pkg::FMT_F32;
            row_length_reg <= bqd_pkg::ROW_LENGTH_RST;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            case (paddr[2])
                bqd_pkg::REG_FORMAT:     format_reg     <= pwdata[1:0];
                bqd_pkg::REG_ROW_LENGTH: row_length_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bqd_pkg::REG_FORMAT: prdata = {30'd0, format_reg};
            default:             prdata = {16'd0, row_length_reg};
        endcase
    end

    bqd_core #(.ROW_INDEX_BITS(ROW_INDEX_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .data_byte(s_tdata), .start_req(s_tuser),
        .format(format_reg), .row_length(row_length_reg),
        .res(res), .res_count(res_count)
    );

    bqd_out u_out (
        .aclk(aclk), .aresetn(aresetn), .load(step),
        .res(res), .res_count(res_count), .ready_in(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );
endmodule
`default_nettype wire

// File: hw/rtl/bqd_checker.sv
// ----------------------------------------------------------------------------
// bqd_checker
// Port-level checks of the dequantizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bqd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output empty");
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken with two results pending");
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind block_quant_dequantizer_top bqd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast), .pready(pready)
);
`default_nettype wire

// File: test/bqd_checker.sv
// ----------------------------------------------------------------------------
// bqd_tb_checker
// Watches the byte and element channels of the dequantizer, computes the
// expected single precision elements and compares every element transfer.
// ----------------------------------------------------------------------------
module bqd_tb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_count,
    output int          element_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BITS = bqd_pkg::ROW_INDEX_BITS_DEF;
    localparam logic [31:0] ROW_MASK = 32'((64'd1 << ROW_BITS) - 64'd1);

    typedef struct packed {
        logic [31:0] bits;
        logic        run_last;
        logic        row_last;
    } element_t;

    element_t          elem_q[$];
    bqd_pkg::fmt_t     cur_fmt;
    logic [15:0]       cur_row_len;
    logic [5:0]        byte_pos;
    logic [15:0]       scale_h;
    logic [23:0]       gathered;
    logic [31:0]       row_idx;

    function automatic int top_bit(input logic [31:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 32; i++) if (v[i]) p = i;
        return p;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] f;
        int p;
        f = {22'd0, h[9:0]};
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
        if (h[14:10] == 5'd0) begin
            if (f == 0) return {h[15], 31'd0};
            p = top_bit(f);
            return {h[15], 8'(p + 103), 23'(f << (23 - p))};
        end
        return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] scale_quant(input logic [15:0] h, input int k);
        logic        sg;
        logic [31:0] m;
        logic [31:0] prod;
        int ak;
        int ex;
        int p;
        sg = h[15] ^ (k < 0);
        ak = k < 0 ? -k : k;
        if (h[14:10] == 5'h1F) begin
            if (h[9:0] != 0) return widen_half(h) | 32'h0040_0000;
            if (ak == 0) return 32'h7FC0_0000;
            return {sg, 8'hFF, 23'd0};
        end
        if (h[14:10] == 0) begin
            m = {22'd0, h[9:0]};
            ex = -24;
        end else begin
            m = {21'd0, 1'b1, h[9:0]};
            ex = int'(h[14:10]) - 25;
        end
        if (m == 0 || ak == 0) return {sg, 31'd0};
        prod = m * ak;
        p = top_bit(prod);
        return {sg, 8'(p + ex + 127), 23'(prod << (23 - p))};
    endfunction

    task automatic push_element(input logic [31:0] bits, input int len, input bit blk,
                                inout int n);
        element_t e;
        e.bits = bits;
        e.run_last = 1'b0;
        e.row_last = (row_idx + 1 >= len);
        row_idx = (row_idx + 1) & ROW_MASK;
        if (!blk && row_idx >= len) row_idx = 0;
        elem_q.push_back(e);
        n++;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic first);
        int size;
        int pos;
        int len;
        int n;
        int lo;
        int hi;
        bit blk;
        n = 0;
        blk = (cur_fmt == bqd_pkg::FMT_Q4_0 || cur_fmt == bqd_pkg::FMT_Q8_0);
        if (first) begin
            byte_pos = 0;
            row_idx = 0;
        end
        case (cur_fmt)
            bqd_pkg::FMT_F32: size = 4;
            bqd_pkg::FMT_F16: size = 2;
            bqd_pkg::FMT_Q4_0: size = 18;
            default: size = 34;
        endcase
        pos = byte_pos;
        if (pos >= size) pos = 0;
        len = cur_row_len == 0 ? 1 : cur_row_len;
        if (len > ROW_MASK) len = ROW_MASK;
        if (cur_fmt == bqd_pkg::FMT_F32) begin
            if (pos == 0) gathered = {16'd0, b};
            else if (pos < 3) gathered = gathered | (24'(b) << (8 * pos));
            else push_element({b, gathered}, len, 0, n);
        end else if (cur_fmt == bqd_pkg::FMT_F16) begin
            if (pos == 0) gathered = {16'd0, b};
            else push_element(widen_half({b, gathered[7:0]}), len, 0, n);
        end else if (pos == 0) begin
            scale_h = {8'd0, b};
        end else if (pos == 1) begin
            scale_h[15:8] = b;
        end else if (cur_fmt == bqd_pkg::FMT_Q8_0) begin
            if (row_idx < len) push_element(scale_quant(scale_h, int'($signed(b))), len, 1, n);
        end else begin
            lo = int'($signed(b[3:0]));
            hi = int'($signed(b[7:4]));
            if (row_idx < len) push_element(scale_quant(scale_h, lo), len, 1, n);
            if (row_idx < len) push_element(scale_quant(scale_h, hi), len, 1, n);
        end
        pos++;
        if (pos >= size) begin
            pos = 0;
            if (blk && row_idx >= len) row_idx = 0;
        end
        byte_pos = 6'(pos);
        if (n > 0) elem_q[$].run_last = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            elem_q.delete();
            cur_fmt <= bqd_pkg::FMT_F32;
            cur_row_len <= 16'd32;
            byte_pos = 0;
            scale_h = 0;
            gathered = 0;
            row_idx = 0;
            fail_count <= 0;
            element_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                element_count <= element_count + 1;
                if (elem_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected element %h last=%b row=%b",
                                 m_tdata, m_tlast, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    if (elem_q[0] != {m_tdata, m_tlast, m_tuser}) begin
                        if (fail_count < 10)
                            $display("mismatch exp %h/%b/%b got %h/%b/%b",
                                     elem_q[0].bits, elem_q[0].run_last,
                                     elem_q[0].row_last, m_tdata, m_tlast, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                    void'(elem_q.pop_front());
                end
            end
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tuser);
            if (psel && penable && pwrite) begin
                if (paddr[2] == bqd_pkg::REG_ROW_LENGTH) cur_row_len <= pwdata[15:0];
                else cur_fmt <= bqd_pkg::fmt_t'(pwdata[1:0]);
            end
        end
    end

    assign pending_count = elem_q.size();
endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives stored tensor bytes through the dequantizer in all four formats and
// several row lengths, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          element_count;
    int          byte_count = 0;
    bit          long_hold = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    block_quant_dequantizer_top dut (.*);
    bqd_tb_checker chk (.*);

    // receiver stall pattern; long hold-off on request
    initial begin
        int stall_len;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (60) @(negedge aclk);
                long_hold = 0;
            end
            stall_len = $urandom_range(0, 7);
            if (stall_len < 3) m_tready <= 0;
            else m_tready <= 1;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        @(negedge aclk);
        s_tvalid <= 1; s_tdata <= b; s_tuser <= first;
        do @(posedge aclk); while (!s_tready);
        byte_count++;
    endtask

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            @(negedge aclk);
            s_tvalid <= 0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mode(input bqd_pkg::fmt_t f, input logic [15:0] len);
        drain();
        reg_write(3'd0, 32'(f));
        reg_write(3'd4, 32'(len));
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_block(input int nbytes, input bit first);
        logic [15:0] h;
        int kind;
        kind = $urandom_range(0, 9);
        h = 16'($urandom);
        if (kind == 0) h[14:10] = 5'h1F;
        else if (kind == 1) h[14:10] = 5'h00;
        for (int i = 0; i < nbytes; i++) begin
            if (i == 0) send_byte(h[7:0], first);
            else if (i == 1) send_byte(h[15:8], 0);
            else send_byte(pick_byte(), 0);
            idle_gap();
        end
    endtask

    initial begin
        #400000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        bqd_pkg::fmt_t f;
        logic [15:0]   len;
        int            n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: reset settings, f32 extremes
        send_byte(8'h00, 1); send_byte(8'h00, 0); send_byte(8'h80, 0); send_byte(8'h7F, 0);
        send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0);
        // f16: inf, nan, subnormal
        set_mode(bqd_pkg::FMT_F16, 16'd0);
        send_byte(8'h00, 1); send_byte(8'h7C, 0); send_byte(8'h01, 0); send_byte(8'hFE, 0);
        send_byte(8'h01, 0); send_byte(8'h80, 0);
        // q8_0 with infinite scale, then short row padding
        set_mode(bqd_pkg::FMT_Q8_0, 16'd3);
        send_byte(8'h00, 1); send_byte(8'hFC, 0);
        send_byte(8'h00, 0); send_byte(8'h80, 0); send_byte(8'h7F, 0);
        for (int i = 0; i < 29; i++) send_byte(8'($urandom), 0);
        // sender pause until all elements drained, then long receiver hold
        drain();
        long_hold = 1;

        for (int ph = 0; ph < 10; ph++) begin
            f = bqd_pkg::fmt_t'(ph % 4);
            case (ph)
                2: len = 16'hFFFF;
                5: len = 16'd1;
                7: len = 16'd0;
                default: len = 16'($urandom_range(1, 70));
            endcase
            set_mode(f, len);
            n = 0;
            if (f == bqd_pkg::FMT_Q4_0 || f == bqd_pkg::FMT_Q8_0) begin
                while (n < 50) begin
                    send_block(f == bqd_pkg::FMT_Q4_0 ? 18 : 34,
                               n == 0 || $urandom_range(0, 9) == 0);
                    n += (f == bqd_pkg::FMT_Q4_0 ? 18 : 34);
                    if (ph == 1 && n > 20) long_hold = 1;
                end
            end else begin
                for (int i = 0; i < 50; i++) begin
                    send_byte(8'($urandom), i == 0 || $urandom_range(0, 40) == 0);
                    idle_gap();
                end
            end
        end
        // format change mid-stream keeps counters
        drain();
        reg_write(3'd0, 32'(bqd_pkg::FMT_Q4_0));
        for (int i = 0; i < 20; i++) send_byte(8'($urandom), 0);
        drain();
        repeat (20) @(posedge aclk);

        $display("bytes sent %0d, elements checked %0d, all four formats", byte_count,
                 element_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
